// File: rtl/lsq_pkg.sv
`default_nettype none

package lsq_pkg;

    // Field widths of one beat
    localparam int OP_W   = 3;
    localparam int HDL_W  = 8;
    localparam int ADDR_W = 64;
    localparam int ASZ_W  = 16;
    localparam int VAL_W  = 64;
    localparam int TICK_W = 64;
    localparam int SEQ_W  = 32;
    localparam int OHDL_W = 6;
    localparam int CNT_W  = 7;
    localparam int CFG_W  = 7;
    localparam int CIDX_W = 1;

    // Entries in each ring, bounded by the handle and count fields
    localparam int LOAD_DEPTH  = 64;
    localparam int STORE_DEPTH = 64;

    // Operation codes of an input beat
    typedef enum logic [OP_W-1:0] {
        OP_ALLOC_LD  = 3'd0,
        OP_ALLOC_ST  = 3'd1,
        OP_COMMIT_LD = 3'd2,
        OP_COMMIT_ST = 3'd3,
        OP_PEEK_LD   = 3'd4,
        OP_PEEK_ST   = 3'd5,
        OP_FLUSH     = 3'd6,
        OP_UNUSED    = 3'd7
    } t_op;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_LOAD_SIZE  = 1'b0;
    localparam logic [CIDX_W-1:0] CFG_STORE_SIZE = 1'b1;

    // Commands handed from the top level to one ring
    localparam logic [2:0] RC_NONE   = 3'd0;
    localparam logic [2:0] RC_ALLOC  = 3'd1;
    localparam logic [2:0] RC_COMMIT = 3'd2;
    localparam logic [2:0] RC_PEEK   = 3'd3;
    localparam logic [2:0] RC_FLUSH  = 3'd4;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [HDL_W-1:0]  handle;
        logic [ADDR_W-1:0] addr;
        logic [ASZ_W-1:0]  asz;
        logic [VAL_W-1:0]  value;
        logic [TICK_W-1:0] tick;
    } t_req;

    typedef struct packed {
        logic              ok;
        logic [OHDL_W-1:0] handle;
        logic [SEQ_W-1:0]  seq;
        logic [ADDR_W-1:0] addr;
        logic [ASZ_W-1:0]  asz;
        logic [VAL_W-1:0]  value;
        logic [TICK_W-1:0] tick;
        logic              committed;
    } t_res;

endpackage

`default_nettype wire

// File: rtl/load_store_queue_rings_top.sv
// Load/store queue built from two ring buffers, one for loads and one for stores, each
// holding its entries in a single-port-write, registered-read memory. Every accepted beat
// gives exactly one result beat. The accept cycle reads the addressed entry from the ring
// memory; in the execute state the block then decides, writes the entry back and loads the
// output register once that register is free. The input side stalls while in the execute
// state, so the block takes no new beat until the last one is finished. Slot valid bits in
// flip-flops make reset and flush take effect at once: there is no clearing pass, and a
// slot not written since reads as all zero. Ring sizes are written through the config
// port; the user must write them only while the block is idle, which the block itself does
// not enforce. A size of 0 reads as 1 and a size above the depth reads as the depth.
`default_nettype none

module load_store_queue_rings_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,

    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [lsq_pkg::OP_W-1:0]      i_op,
    input  wire logic [lsq_pkg::HDL_W-1:0]     i_handle,
    input  wire logic [lsq_pkg::ADDR_W-1:0]    i_addr,
    input  wire logic [lsq_pkg::ASZ_W-1:0]     i_access_size,
    input  wire logic [lsq_pkg::VAL_W-1:0]     i_store_value,
    input  wire logic [lsq_pkg::TICK_W-1:0]    i_alloc_tick,

    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_ok,
    output logic      [lsq_pkg::OHDL_W-1:0]    o_out_handle,
    output logic      [lsq_pkg::SEQ_W-1:0]     o_entry_seq,
    output logic      [lsq_pkg::ADDR_W-1:0]    o_entry_addr,
    output logic      [lsq_pkg::ASZ_W-1:0]     o_entry_size,
    output logic      [lsq_pkg::VAL_W-1:0]     o_entry_value,
    output logic      [lsq_pkg::TICK_W-1:0]    o_entry_tick,
    output logic                               o_entry_committed,
    output logic      [lsq_pkg::CNT_W-1:0]     o_load_count,
    output logic      [lsq_pkg::CNT_W-1:0]     o_store_count,

    input  wire logic                          i_cfg_wr_en,
    input  wire logic [lsq_pkg::CIDX_W-1:0]    i_cfg_index,
    input  wire logic [lsq_pkg::CFG_W-1:0]     i_cfg_data
);

    import lsq_pkg::*;

    localparam int LSW = $clog2(LOAD_DEPTH + 1);
    localparam int SSW = $clog2(STORE_DEPTH + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic             r_state, n_state;
    logic [LSW-1:0]   r_ld_size;
    logic [SSW-1:0]   r_st_size;
    logic             r_out_valid;
    t_res             r_res;
    logic [CNT_W-1:0] r_ld_cnt;
    logic [CNT_W-1:0] r_st_cnt;

    logic             w_accept;
    logic             w_finish;
    logic [2:0]       w_ld_cmd;
    logic [2:0]       w_st_cmd;
    t_req             w_ld_req;
    t_req             w_st_req;
    t_res             w_ld_res;
    t_res             w_st_res;
    logic [CNT_W-1:0] w_ld_cnt;
    logic [CNT_W-1:0] w_st_cnt;

    function automatic logic [8:0] f_clamp(input logic [CFG_W-1:0] v, input int depth);
        logic [8:0] vx;
        vx = {2'b00, v};
        if (vx == 9'd0) begin
            return 9'd1;
        end
        if (vx > 9'(depth)) begin
            return 9'(depth);
        end
        return vx;
    endfunction

    // Ring size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ld_size <= LSW'(f_clamp(7'd32, LOAD_DEPTH));
            r_st_size <= SSW'(f_clamp(7'd32, STORE_DEPTH));
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_LOAD_SIZE:  r_ld_size <= LSW'(f_clamp(i_cfg_data, LOAD_DEPTH));
                CFG_STORE_SIZE: r_st_size <= SSW'(f_clamp(i_cfg_data, STORE_DEPTH));
                default: begin
                end
            endcase
        end
    end

    // Steer the op to the rings
    always_comb begin
        w_ld_cmd = RC_NONE;
        w_st_cmd = RC_NONE;
        case (i_op)
            OP_ALLOC_LD:  w_ld_cmd = RC_ALLOC;
            OP_ALLOC_ST:  w_st_cmd = RC_ALLOC;
            OP_COMMIT_LD: w_ld_cmd = RC_COMMIT;
            OP_COMMIT_ST: w_st_cmd = RC_COMMIT;
            OP_PEEK_LD:   w_ld_cmd = RC_PEEK;
            OP_PEEK_ST:   w_st_cmd = RC_PEEK;
            OP_FLUSH: begin
                w_ld_cmd = RC_FLUSH;
                w_st_cmd = RC_FLUSH;
            end
            default: begin
            end
        endcase
    end

    assign w_ld_req = '{cmd: w_ld_cmd, handle: i_handle, addr: i_addr, asz: i_access_size,
                        value: i_store_value, tick: i_alloc_tick};
    assign w_st_req = '{cmd: w_st_cmd, handle: i_handle, addr: i_addr, asz: i_access_size,
                        value: i_store_value, tick: i_alloc_tick};

    // Accept in idle, finish once the output register is free
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_finish   = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_accept) n_state = S_EXEC;
            S_EXEC: if (w_finish) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    lsq_ring #(
        .DEPTH     (LOAD_DEPTH),
        .HAS_VALUE (1'b0)
    ) u_load_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_size   (r_ld_size),
        .i_start  (w_accept),
        .i_req    (w_ld_req),
        .i_finish (w_finish),
        .o_res    (w_ld_res),
        .o_count  (w_ld_cnt)
    );

    lsq_ring #(
        .DEPTH     (STORE_DEPTH),
        .HAS_VALUE (1'b1)
    ) u_store_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_size   (r_st_size),
        .i_start  (w_accept),
        .i_req    (w_st_req),
        .i_finish (w_finish),
        .o_res    (w_st_res),
        .o_count  (w_st_cnt)
    );

    // Output register: only the addressed ring drives a nonzero result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_res    <= t_res'(w_ld_res | w_st_res);
            r_ld_cnt <= w_ld_cnt;
            r_st_cnt <= w_st_cnt;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_ok              = r_res.ok;
    assign o_out_handle      = r_res.handle;
    assign o_entry_seq       = r_res.seq;
    assign o_entry_addr      = r_res.addr;
    assign o_entry_size      = r_res.asz;
    assign o_entry_value     = r_res.value;
    assign o_entry_tick      = r_res.tick;
    assign o_entry_committed = r_res.committed;
    assign o_load_count      = r_ld_cnt;
    assign o_store_count     = r_st_cnt;

endmodule

`default_nettype wire

// File: rtl/lsq_ram.sv
`default_nettype none

module lsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: rtl/lsq_ring.sv
`default_nettype none

module lsq_ring #(
    parameter int DEPTH     = 64,
    parameter bit HAS_VALUE = 1'b0
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [$clog2(DEPTH+1)-1:0]   i_size,
    input  wire logic                         i_start,
    input  wire lsq_pkg::t_req                i_req,
    input  wire logic                         i_finish,
    output lsq_pkg::t_res                     o_res,
    output logic      [lsq_pkg::CNT_W-1:0]    o_count
);

    import lsq_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int SW = $clog2(DEPTH + 1);
    localparam int HW = (SW > HDL_W) ? SW : HDL_W;
    localparam int XW = (SW > CNT_W) ? SW : CNT_W;
    localparam int OW = (PW > OHDL_W) ? PW : OHDL_W;
    localparam int EW = SEQ_W + ADDR_W + ASZ_W + TICK_W + 1 + (HAS_VALUE ? VAL_W : 0);

    logic [PW-1:0]    r_head, n_head;
    logic [PW-1:0]    r_tail, n_tail;
    logic [SW-1:0]    r_occ, n_occ;
    logic [SEQ_W-1:0] r_seq, n_seq;
    logic [DEPTH-1:0] r_valid, n_valid;
    t_req             r_req;

    logic [HW-1:0]     w_hdl_x;
    logic [HW-1:0]     w_size_x;
    logic              w_hdl_in;
    logic [PW-1:0]     w_hdl;
    logic [SEQ_W-1:0]  w_seq_inc;
    logic              w_alloc_ok;
    logic              w_head_hit;

    logic [EW-1:0]     w_rd_data;
    logic [EW-1:0]     w_wr_data;
    logic              w_wr_en;
    logic [PW-1:0]     w_wr_addr;

    logic [SEQ_W-1:0]  w_rd_seq, w_cur_seq, w_wd_seq;
    logic [ADDR_W-1:0] w_rd_addr, w_cur_addr, w_wd_addr;
    logic [ASZ_W-1:0]  w_rd_asz, w_cur_asz, w_wd_asz;
    logic [VAL_W-1:0]  w_rd_val, w_cur_val, w_wd_val;
    logic [TICK_W-1:0] w_rd_tick, w_cur_tick, w_wd_tick;
    logic              w_rd_com, w_cur_com, w_wd_com;

    logic [XW-1:0]     w_cnt_x;
    logic [OW-1:0]     w_tail_x;
    t_res              w_res;

    function automatic logic [PW-1:0] f_advance(input logic [PW-1:0] p,
                                                input logic [SW-1:0] size);
        logic [SW:0] p1;
        p1 = (SW+1)'(p) + (SW+1)'(1);
        if (p1 >= (SW+1)'(size)) begin
            return '0;
        end
        return p1[PW-1:0];
    endfunction

    // Entry memory: read at accept, written back at finish
    lsq_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en & i_finish),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (i_start),
        .i_rd_addr (i_req.handle[PW-1:0]),
        .o_rd_data (w_rd_data)
    );

    // Pack and unpack one entry
    generate
        if (HAS_VALUE) begin : g_val
            assign {w_rd_seq, w_rd_addr, w_rd_asz, w_rd_val, w_rd_tick, w_rd_com} = w_rd_data;
            assign w_wr_data = {w_wd_seq, w_wd_addr, w_wd_asz, w_wd_val, w_wd_tick, w_wd_com};
        end else begin : g_noval
            assign {w_rd_seq, w_rd_addr, w_rd_asz, w_rd_tick, w_rd_com} = w_rd_data;
            assign w_rd_val  = '0;
            assign w_wr_data = {w_wd_seq, w_wd_addr, w_wd_asz, w_wd_tick, w_wd_com};
        end
    endgenerate

    // Handle range check and current entry, zero where never written
    assign w_hdl_x   = HW'(r_req.handle);
    assign w_size_x  = HW'(i_size);
    assign w_hdl_in  = (w_hdl_x < w_size_x);
    assign w_hdl     = w_hdl_x[PW-1:0];
    assign w_seq_inc = r_seq + SEQ_W'(1);

    always_comb begin
        if (r_valid[w_hdl]) begin
            w_cur_seq  = w_rd_seq;
            w_cur_addr = w_rd_addr;
            w_cur_asz  = w_rd_asz;
            w_cur_val  = w_rd_val;
            w_cur_tick = w_rd_tick;
            w_cur_com  = w_rd_com;
        end else begin
            w_cur_seq  = '0;
            w_cur_addr = '0;
            w_cur_asz  = '0;
            w_cur_val  = '0;
            w_cur_tick = '0;
            w_cur_com  = 1'b0;
        end
    end

    // Decode the command against pointers and occupancy
    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_occ      = r_occ;
        n_seq      = r_seq;
        n_valid    = r_valid;
        w_wr_en    = 1'b0;
        w_wr_addr  = r_tail;
        w_wd_seq   = r_seq;
        w_wd_addr  = r_req.addr;
        w_wd_asz   = r_req.asz;
        w_wd_val   = r_req.value;
        w_wd_tick  = r_req.tick;
        w_wd_com   = 1'b0;
        w_alloc_ok = 1'b0;
        w_head_hit = 1'b0;
        w_res      = '0;
        w_tail_x   = OW'(r_tail);

        case (r_req.cmd)
            RC_ALLOC: begin
                if (r_occ < i_size) begin
                    w_alloc_ok       = 1'b1;
                    w_wr_en          = 1'b1;
                    n_valid[r_tail]  = 1'b1;
                    n_tail           = f_advance(r_tail, i_size);
                    n_occ            = r_occ + SW'(1);
                    n_seq            = (w_seq_inc == '0) ? SEQ_W'(1) : w_seq_inc;
                    w_res.ok         = 1'b1;
                    w_res.handle     = w_tail_x[OHDL_W-1:0];
                end
            end
            RC_COMMIT: begin
                if (w_hdl_in && (r_occ != '0)) begin
                    if (w_hdl == r_head) begin
                        // Free the head slot
                        w_head_hit      = 1'b1;
                        n_valid[r_head] = 1'b0;
                        n_head          = f_advance(r_head, i_size);
                        n_occ           = r_occ - SW'(1);
                        w_res.ok        = 1'b1;
                    end else begin
                        // Mark only; write the entry back with its mark set
                        w_wr_en        = 1'b1;
                        w_wr_addr      = w_hdl;
                        w_wd_seq       = w_cur_seq;
                        w_wd_addr      = w_cur_addr;
                        w_wd_asz       = w_cur_asz;
                        w_wd_val       = w_cur_val;
                        w_wd_tick      = w_cur_tick;
                        w_wd_com       = 1'b1;
                        n_valid[w_hdl] = 1'b1;
                    end
                end
            end
            RC_PEEK: begin
                if (w_hdl_in) begin
                    w_res.ok        = 1'b1;
                    w_res.seq       = w_cur_seq;
                    w_res.addr      = w_cur_addr;
                    w_res.asz       = w_cur_asz;
                    w_res.value     = w_cur_val;
                    w_res.tick      = w_cur_tick;
                    w_res.committed = w_cur_com;
                end
            end
            RC_FLUSH: begin
                n_head  = '0;
                n_tail  = '0;
                n_occ   = '0;
                n_valid = '0;
            end
            default: begin
            end
        endcase
    end

    assign w_cnt_x = XW'(n_occ);
    assign o_count = w_cnt_x[CNT_W-1:0];
    assign o_res   = w_res;

    // Hold the beat through the execute state
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_req <= i_req;
        end
    end

    // Advance pointers and valid bits when the result moves out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_occ   <= '0;
            r_seq   <= SEQ_W'(1);
            r_valid <= '0;
        end else if (i_finish) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_occ   <= n_occ;
            r_seq   <= n_seq;
            r_valid <= n_valid;
        end
    end

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= SW'(DEPTH))
        else $error("ring occupancy above depth");

    a_flush_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_finish && (r_req.cmd == RC_FLUSH)) |=> ((r_occ == '0) && (r_valid == '0)))
        else $error("ring not empty after flush");

    a_alloc_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_finish && w_alloc_ok) |=> ((r_occ == $past(r_occ) + SW'(1)) && r_valid[$past(r_tail)]))
        else $error("allocation did not fill the tail slot");

    a_head_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_finish && w_head_hit) |=> (!r_valid[$past(r_head)] && (r_occ == $past(r_occ) - SW'(1))))
        else $error("head commit did not free the slot");
`endif

endmodule

`default_nettype wire
